>>> src/isfp_pkg.sv
`timescale 1ns / 1ps

package isfp_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_ACC  = 8'h51;
    localparam logic [7:0] TYPE_GYRO = 8'h52;
    localparam logic [7:0] TYPE_QUAT = 8'h59;

    localparam int PAYLOAD_BYTES = 8;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    localparam logic [1:0] KIND_ACC  = 2'd0;
    localparam logic [1:0] KIND_GYRO = 2'd1;
    localparam logic [1:0] KIND_QUAT = 2'd2;

    typedef logic [7:0]         byte_t;
    typedef logic [1:0]         kind_t;
    typedef logic signed [15:0] word_t;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_TYPE  = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

endpackage

>>> src/isfp_byte_if.sv
`timescale 1ns / 1ps

interface isfp_byte_if;
    import isfp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> src/isfp_frame_if.sv
`timescale 1ns / 1ps

interface isfp_frame_if;
    import isfp_pkg::*;

    logic  valid;
    logic  ready;
    kind_t frame_kind;
    word_t word0;
    word_t word1;
    word_t word2;
    word_t word3;

    modport source (output valid, output frame_kind, output word0, output word1,
                    output word2, output word3, input ready);
    modport sink   (input valid, input frame_kind, input word0, input word1,
                    input word2, input word3, output ready);
endinterface

>>> src/imu_serial_frame_parser.sv
`timescale 1ns / 1ps

// Parser for 11-byte IMU serial frames: header 0x55, type byte, eight
// payload bytes, checksum (8-bit sum of the first ten bytes).
// rx:    one received byte per request.
// frame: one request per good frame: kind (0 accel, 1 rate, 2 quaternion)
//        and four little-endian signed 16-bit words.
// Throughput: one byte per cycle except while a checksum byte is stalled.
// Bytes other than the checksum are taken even while a decoded frame
// waits on the output register. The frame request is registered and
// is valid in the cycle after the checksum byte is accepted.
// Stall: while a frame is held in the output register and the receiver is
// not ready, a checksum byte is not accepted; that is the only byte the
// single output register cannot absorb.
// Reset: parser goes back to hunting for a header and the output register
// is emptied. The payload buffer is not cleared; every byte of it is
// written before a frame reads it.
// Bad type bytes, checksum mismatches and stray bytes give no request.

module imu_serial_frame_parser (
    input  logic clk,
    input  logic rst_n,
    isfp_byte_if.sink    rx,
    isfp_frame_if.source frame
);
    import isfp_pkg::*;

    phase_t           phase_reg, phase_next;
    kind_t            kind_reg, kind_next;
    logic [IDX_W-1:0] count_reg, count_next;
    byte_t            sum_reg, sum_next;
    byte_t            store_reg [PAYLOAD_BYTES];

    logic  out_valid_reg;
    kind_t out_kind_reg;
    word_t out_word_reg [4];

    logic  in_fire;
    logic  good_frame;
    byte_t sum_add;

    assign rx.ready = !(phase_reg == PH_CHECK && out_valid_reg && !frame.ready);
    assign in_fire  = rx.valid && rx.ready;
    assign sum_add  = sum_reg + rx.rx_byte;
    assign good_frame = in_fire && phase_reg == PH_CHECK && rx.rx_byte == sum_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HUNT:
                    if (rx.rx_byte == HDR_BYTE)
                        phase_next = PH_TYPE;
                PH_TYPE:
                begin
                    case (rx.rx_byte) inside
                        HDR_BYTE:                       phase_next = PH_TYPE;
                        TYPE_ACC, TYPE_GYRO, TYPE_QUAT: phase_next = PH_DATA;
                        default:                        phase_next = PH_HUNT;
                    endcase
                end
                PH_DATA:
                    if (count_reg == IDX_W'(PAYLOAD_BYTES - 1))
                        phase_next = PH_CHECK;
                PH_CHECK:
                    phase_next = PH_HUNT;
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    // frame bookkeeping
    always_comb
    begin
        kind_next  = kind_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    sum_next   = HDR_BYTE;
                    count_next = '0;
                end
                PH_TYPE:
                begin
                    count_next = '0;
                    if (rx.rx_byte == HDR_BYTE)
                        sum_next = HDR_BYTE;
                    else
                        sum_next = sum_add;
                    if (rx.rx_byte == TYPE_ACC)
                        kind_next = KIND_ACC;
                    else if (rx.rx_byte == TYPE_GYRO)
                        kind_next = KIND_GYRO;
                    else if (rx.rx_byte == TYPE_QUAT)
                        kind_next = KIND_QUAT;
                end
                PH_DATA:
                begin
                    sum_next   = sum_add;
                    count_next = count_reg + 1'b1;
                end
                PH_CHECK:
                    count_next = '0;
                default:
                    count_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            kind_reg  <= KIND_ACC;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && phase_reg == PH_DATA)
            store_reg[count_reg] <= rx.rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (good_frame)
            out_valid_reg <= 1'b1;
        else if (frame.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (good_frame)
        begin
            out_kind_reg <= kind_reg;
            for (int i = 0; i < 4; i++)
                out_word_reg[i] <= {store_reg[2*i+1], store_reg[2*i]};
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_kind = out_kind_reg;
    assign frame.word0      = out_word_reg[0];
    assign frame.word1      = out_word_reg[1];
    assign frame.word2      = out_word_reg[2];
    assign frame.word3      = out_word_reg[3];

    // a held frame must block the checksum byte of the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHECK && out_valid_reg && !frame.ready |-> !rx.ready)
        else $error("checksum byte accepted while output register is full");

    // a new frame request comes only from an accepted checksum byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (!$past(out_valid_reg) || $past(frame.ready))
        |-> $past(in_fire && phase_reg == PH_CHECK))
        else $error("frame request without a checksum byte");

    // last payload byte always leads to the checksum phase
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_DATA && count_reg == IDX_W'(PAYLOAD_BYTES - 1)
        |=> phase_reg == PH_CHECK)
        else $error("payload count did not end the data phase");

    // every frame enters the data phase with an empty payload count
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA && $past(phase_reg) == PH_TYPE |-> count_reg == '0)
        else $error("payload count not cleared at start of data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_kind_reg == KIND_ACC || out_kind_reg == KIND_GYRO ||
                           out_kind_reg == KIND_QUAT))
        else $error("invalid frame kind on output");

endmodule

>>> bench/imu_serial_frame_parser_test.sv
`timescale 1ns / 1ps

module imu_serial_frame_parser_test;
    import isfp_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int BYTES_PER_PH = 550;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        kind_t kind;
        word_t words [4];
    } frame_t;

    // Shadow parser plus the queue of frames it says must come out.
    class frame_scoreboard;
        phase_t      phase;
        kind_t       kind_held;
        logic [3:0]  payload_count;
        byte_t       running_sum;
        byte_t       payload [8];
        frame_t      pending_frames [$];
        int          mismatches;

        function new();
            phase         = PH_HUNT;
            kind_held     = KIND_ACC;
            payload_count = '0;
            running_sum   = '0;
            mismatches    = 0;
        endfunction

        function void start_frame();
            running_sum   = HDR_BYTE;
            payload_count = '0;
            phase         = PH_TYPE;
        endfunction

        function void note_byte(byte_t b);
            frame_t f;
            case (phase)
                PH_HUNT:
                begin
                    if (b == HDR_BYTE)
                        start_frame();
                end
                PH_TYPE:
                begin
                    if (b == HDR_BYTE)
                        start_frame();
                    else if (b == TYPE_ACC || b == TYPE_GYRO || b == TYPE_QUAT)
                    begin
                        kind_held     = (b == TYPE_ACC) ? KIND_ACC :
                                        (b == TYPE_GYRO) ? KIND_GYRO : KIND_QUAT;
                        running_sum   = running_sum + b;
                        payload_count = '0;
                        phase         = PH_DATA;
                    end
                    else
                        phase = PH_HUNT;
                end
                PH_DATA:
                begin
                    payload[payload_count[2:0]] = b;
                    running_sum   = running_sum + b;
                    payload_count = payload_count + 4'd1;
                    if (payload_count >= 4'd8)
                        phase = PH_CHECK;
                end
                PH_CHECK:
                begin
                    phase         = PH_HUNT;
                    payload_count = '0;
                    if (b == running_sum)
                    begin
                        f.kind = kind_held;
                        for (int i = 0; i < 4; i++)
                            f.words[i] = {payload[2*i+1], payload[2*i]};
                        pending_frames.push_back(f);
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            if (mismatches <= 50)
                $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
        endtask

        task check_frame(kind_t kind, word_t w0, word_t w1, word_t w2, word_t w3);
            frame_t want;
            word_t  got [4];
            if (pending_frames.size() == 0)
            begin
                report_mismatch("frame with nothing pending, kind", 16'(kind), '0);
                return;
            end
            want = pending_frames.pop_front();
            got  = '{w0, w1, w2, w3};
            if (kind !== want.kind)
                report_mismatch("frame_kind", 16'(kind), 16'(want.kind));
            for (int i = 0; i < 4; i++)
                if (got[i] !== want.words[i])
                    report_mismatch($sformatf("word%0d", i), got[i], want.words[i]);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_len = 0;
    int   hold_count = 0;
    int   cycle_count = 0;
    int   counted_bytes = 0;

    frame_scoreboard sb = new();

    isfp_byte_if  rx_if ();
    isfp_frame_if frame_if ();

    imu_serial_frame_parser DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frame (frame_if)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, or one long hold once its length is set.
    always @(posedge clk)
    begin
        if (hold_count < hold_len)
        begin
            frame_if.ready <= 1'b0;
            hold_count     <= hold_count + 1;
        end
        else
            frame_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rx_if.valid && rx_if.ready)
            sb.note_byte(rx_if.rx_byte);
        if (rst_n && frame_if.valid && frame_if.ready)
            sb.check_frame(frame_if.frame_kind, frame_if.word0, frame_if.word1,
                           frame_if.word2, frame_if.word3);
    end

    task send_byte(input byte_t b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
    endtask

    task send_frame(input byte_t type_code, input byte_t body [8], input bit corrupt);
        byte_t sum;
        sum = HDR_BYTE + type_code;
        send_byte(HDR_BYTE);
        send_byte(type_code);
        for (int i = 0; i < 8; i++)
        begin
            send_byte(body[i]);
            sum = sum + body[i];
        end
        if (corrupt)
            sum = sum ^ byte_t'($urandom_range(1, 255));
        send_byte(sum);
        counted_bytes += 11;
    endtask

    task random_frame();
        byte_t body [8];
        byte_t type_code;
        for (int i = 0; i < 8; i++)
            body[i] = ($urandom_range(0, 15) == 0) ? HDR_BYTE : byte_t'($urandom);
        case ($urandom_range(0, 2))
            0: type_code = TYPE_ACC;
            1: type_code = TYPE_GYRO;
            default: type_code = TYPE_QUAT;
        endcase
        send_frame(type_code, body, $urandom_range(0, 9) == 0);
    endtask

    function automatic byte_t unknown_type();
        byte_t t;
        do
            t = byte_t'($urandom);
        while (t == HDR_BYTE || t == TYPE_ACC || t == TYPE_GYRO || t == TYPE_QUAT);
        return t;
    endfunction

    task broken_sequence();
        int n;
        case ($urandom_range(0, 2))
            0:
            begin
                send_byte(HDR_BYTE);
                send_byte(unknown_type());
                counted_bytes += 2;
            end
            1:
            begin
                // extra header right before a frame restarts it
                send_byte(HDR_BYTE);
                counted_bytes += 1;
                random_frame();
            end
            default:
            begin
                // cut-off frame; what follows is swallowed as its payload
                n = $urandom_range(0, 7);
                send_byte(HDR_BYTE);
                send_byte(($urandom_range(0, 1) == 0) ? TYPE_ACC : TYPE_QUAT);
                for (int i = 0; i < n; i++)
                    send_byte(byte_t'($urandom));
                counted_bytes += n + 2;
            end
        endcase
    endtask

    task wait_drained();
        while (sb.pending_frames.size() != 0)
            @(posedge clk);
    endtask

    task random_run(input int target);
        int start;
        int n;
        start = counted_bytes;
        while (counted_bytes - start < target)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                        send_byte(byte_t'($urandom));
                    counted_bytes += n;
                end
                1, 2:    broken_sequence();
                default: random_frame();
            endcase
        end
        rx_if.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
    endtask

    initial
    begin
        byte_t body [8];
        rst_n          <= 1'b0;
        rx_if.valid    <= 1'b0;
        rx_if.rx_byte  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray bytes while hunting, then a doubled header
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(HDR_BYTE);
        // extremes of the words, header value inside the payload
        body = '{8'h00, 8'h80, 8'hff, 8'h7f, 8'h55, 8'h55, 8'hff, 8'hff};
        send_frame(TYPE_ACC, body, 1'b0);
        send_byte(HDR_BYTE);
        send_byte(unknown_type());
        body = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 8'hde, 8'hf0};
        send_frame(TYPE_GYRO, body, 1'b1);
        body = '{8'h01, 8'h00, 8'hff, 8'hff, 8'h00, 8'h80, 8'h34, 8'h12};
        send_frame(TYPE_QUAT, body, 1'b0);
        send_frame(TYPE_GYRO, body, 1'b0);
        rx_if.valid <= 1'b0;
        @(posedge clk);
        wait_drained();

        send_idle_pct = 7;
        recv_idle_pct = 56;
        random_run(BYTES_PER_PH);

        send_idle_pct = 56;
        recv_idle_pct = 7;
        random_run(BYTES_PER_PH);

        // back-to-back frames into a held receiver fill the output and stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len <= LONG_HOLD;
        random_run(BYTES_PER_PH);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending_frames.size() != 0)
            sb.report_mismatch("frames never delivered", 16'(sb.pending_frames.size()), '0);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
